// File: design/msic_pkg.sv
`default_nettype none

package msic_pkg;

  // Capacity of the element store
  localparam int MAX_ELEMENTS = 64;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  // Counts and indexes that must hold MAX_ELEMENTS itself
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  // Run width doubles past the count on the last pass
  localparam int WID_W        = CNT_W + 1;
  // Segment bound sums: base + 2 * width
  localparam int SUM_W        = CNT_W + 2;

  localparam int DATA_W       = 32;
  localparam int INV_W        = 11;
  localparam logic [INV_W-1:0] INV_MAX = '1;
  // Largest reachable inversion count: n * (n - 1) / 2
  localparam int INV_BOUND    = MAX_ELEMENTS * (MAX_ELEMENTS - 1) / 2;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_INIT,
    ST_MERGE,
    ST_EMIT
  } msic_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic init;
    logic step;
    logic start_emit;
    logic emit;
    logic clear;
  } msic_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic set_end;
    logic sort_done;
    logic emit_final;
  } msic_stat_t;

endpackage

`default_nettype wire

// File: design/msic_if.sv
`default_nettype none

// Input item channel
interface msic_in_if;
  import msic_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink   (input valid, input value, input is_last, output ready);
endinterface

// Sorted result channel
interface msic_out_if;
  import msic_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     last_out;
  logic [INV_W-1:0]         inversion_total;
  logic                     overflow;

  modport source (output valid, output sorted_value, output last_out,
                  output inversion_total, output overflow, input ready);
  modport sink   (input valid, input sorted_value, input last_out,
                  input inversion_total, input overflow, output ready);
endinterface

`default_nettype wire

// File: design/msic_ctrl.sv
`default_nettype none

module msic_ctrl import msic_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  msic_stat_t stat,
  output msic_cmd_t  cmd
);

  msic_state_t st_r, st_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_LOAD;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_LOAD:  if (stat.set_end) st_nxt = ST_INIT;
      ST_INIT:  st_nxt = ST_MERGE;
      ST_MERGE: if (stat.sort_done) st_nxt = ST_EMIT;
      ST_EMIT:  if (stat.emit_final) st_nxt = ST_LOAD;
      default:  st_nxt = ST_LOAD;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    case (st_r)
      ST_LOAD:  cmd.load = 1'b1;
      ST_INIT:  cmd.init = 1'b1;
      ST_MERGE: begin
        cmd.start_emit = stat.sort_done;
        cmd.step       = !stat.sort_done;
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        cmd.clear = stat.emit_final;
      end
      default:  cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: design/msic_datapath.sv
`default_nettype none

module msic_datapath import msic_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  msic_cmd_t                cmd,
  output msic_stat_t               stat,
  input  logic                     in_valid,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     in_is_last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     out_last,
  output logic [INV_W-1:0]         out_inv,
  output logic                     out_ovf
);

  // Two banks; merges ping-pong between them
  logic signed [DATA_W-1:0] bank_a [MAX_ELEMENTS];
  logic signed [DATA_W-1:0] bank_b [MAX_ELEMENTS];
  logic signed [DATA_W-1:0] rda0_r, rda1_r, rdb0_r, rdb1_r;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [INV_W-1:0] inv_r, inv_nxt;
  logic [WID_W-1:0] wid_r, wid_nxt;
  logic [CNT_W-1:0] mid_r, mid_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] e_r, e_nxt;
  logic             src_r, src_nxt;  // 0: bank_a is the source

  logic                     out_vld_r, out_vld_nxt;
  logic signed [DATA_W-1:0] out_value_r;
  logic                     out_last_r;
  logic [INV_W-1:0]         out_inv_r;
  logic                     out_ovf_r;

  logic                     in_fire, store_we, room;
  logic signed [DATA_W-1:0] rd0, rd1, mv_data;
  logic                     left_avail, right_avail, take_left;
  logic                     seg_end, pass_end;
  logic [CNT_W-1:0]         seg_base;
  logic [WID_W-1:0]         seg_wid;
  logic [SUM_W-1:0]         sum_mid, sum_hi;
  logic [CNT_W-1:0]         mid_new, hi_new;
  logic [INV_W:0]           inv_add;
  logic [INV_W-1:0]         inv_sat;
  logic                     out_load, e_final;
  logic [IDX_W-1:0]         addr0, addr1;

  assign in_fire  = cmd.load && in_valid;
  assign room     = cnt_r < CNT_W'(MAX_ELEMENTS);
  assign store_we = in_fire && room;

  // Run heads of the source bank
  assign rd0 = src_r ? rdb0_r : rda0_r;
  assign rd1 = src_r ? rdb1_r : rda1_r;

  // Stable merge choice: left wins ties
  assign left_avail  = i_r < mid_r;
  assign right_avail = j_r < hi_r;
  assign take_left   = left_avail && (!right_avail || (rd0 <= rd1));
  assign mv_data     = take_left ? rd0 : rd1;

  assign seg_end  = CNT_W'(k_r + 1'b1) == hi_r;
  assign pass_end = seg_end && (hi_r == cnt_r);

  // Bounds of the next segment pair
  always_comb begin
    if (cmd.init) begin
      seg_base = '0;
      seg_wid  = WID_W'(1);
    end else if (pass_end) begin
      seg_base = '0;
      seg_wid  = WID_W'(wid_r << 1);
    end else begin
      seg_base = hi_r;
      seg_wid  = wid_r;
    end
  end

  assign sum_mid = SUM_W'(seg_base) + SUM_W'(seg_wid);
  assign sum_hi  = SUM_W'(seg_base) + SUM_W'(SUM_W'(seg_wid) << 1);
  assign mid_new = (sum_mid >= SUM_W'(cnt_r)) ? cnt_r : CNT_W'(sum_mid);
  assign hi_new  = (sum_hi >= SUM_W'(cnt_r)) ? cnt_r : CNT_W'(sum_hi);

  // Left elements still waiting, saturating
  assign inv_add = {1'b0, inv_r} + (INV_W + 1)'(mid_r - i_r);
  assign inv_sat = (inv_add > {1'b0, INV_MAX}) ? INV_MAX : inv_add[INV_W-1:0];

  // Emission into the output register
  assign out_load = cmd.emit && (!out_vld_r || out_ready) && (e_r < cnt_r);
  assign e_final  = CNT_W'(e_r + 1'b1) == cnt_r;

  assign stat.set_end    = in_fire && in_is_last;
  assign stat.sort_done  = wid_r >= WID_W'(cnt_r);
  assign stat.emit_final = out_load && e_final;

  // Next-state logic
  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    inv_nxt = inv_r;
    wid_nxt = wid_r;
    mid_nxt = mid_r;
    hi_nxt  = hi_r;
    i_nxt   = i_r;
    j_nxt   = j_r;
    k_nxt   = k_r;
    e_nxt   = e_r;
    src_nxt = src_r;

    if (in_fire) begin
      if (room) cnt_nxt = CNT_W'(cnt_r + 1'b1);
      else      ovf_nxt = 1'b1;
    end

    if (cmd.init) begin
      wid_nxt = WID_W'(1);
      src_nxt = 1'b0;
      inv_nxt = '0;
      i_nxt   = '0;
      j_nxt   = mid_new;
      mid_nxt = mid_new;
      hi_nxt  = hi_new;
      k_nxt   = '0;
    end

    if (cmd.step) begin
      k_nxt = CNT_W'(k_r + 1'b1);
      if (take_left) begin
        i_nxt = CNT_W'(i_r + 1'b1);
      end else begin
        j_nxt = CNT_W'(j_r + 1'b1);
        if (left_avail) inv_nxt = inv_sat;
      end
      if (seg_end) begin
        i_nxt   = seg_base;
        j_nxt   = mid_new;
        mid_nxt = mid_new;
        hi_nxt  = hi_new;
        k_nxt   = seg_base;
        if (pass_end) begin
          wid_nxt = WID_W'(wid_r << 1);
          src_nxt = !src_r;
        end
      end
    end

    if (cmd.start_emit) e_nxt = '0;
    if (out_load)       e_nxt = CNT_W'(e_r + 1'b1);

    if (cmd.clear) begin
      cnt_nxt = '0;
      ovf_nxt = 1'b0;
    end
  end

  // Output valid
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_load)       out_vld_nxt = 1'b1;
    else if (out_ready) out_vld_nxt = 1'b0;
  end

  // Read addresses follow the next head positions
  assign addr0 = (cmd.emit || cmd.start_emit) ? e_nxt[IDX_W-1:0] : i_nxt[IDX_W-1:0];
  assign addr1 = j_nxt[IDX_W-1:0];

  // Bank A: loads and merge writes; the right head sees a same-cycle write
  always_ff @(posedge clk) begin
    if (store_we) begin
      bank_a[cnt_r[IDX_W-1:0]] <= in_value;
    end else if (cmd.step && src_r) begin
      bank_a[k_r[IDX_W-1:0]] <= mv_data;
    end
    rda0_r <= bank_a[addr0];
    if (cmd.step && src_r && (k_r[IDX_W-1:0] == addr1)) begin
      rda1_r <= mv_data;
    end else begin
      rda1_r <= bank_a[addr1];
    end
  end

  // Bank B: merge writes only; the right head sees a same-cycle write
  always_ff @(posedge clk) begin
    if (cmd.step && !src_r) begin
      bank_b[k_r[IDX_W-1:0]] <= mv_data;
    end
    rdb0_r <= bank_b[addr0];
    if (cmd.step && !src_r && (k_r[IDX_W-1:0] == addr1)) begin
      rdb1_r <= mv_data;
    end else begin
      rdb1_r <= bank_b[addr1];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      inv_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      ovf_r     <= ovf_nxt;
      inv_r     <= inv_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Merge indexes and output payload
  always_ff @(posedge clk) begin
    wid_r <= wid_nxt;
    mid_r <= mid_nxt;
    hi_r  <= hi_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
    e_r   <= e_nxt;
    src_r <= src_nxt;
    if (out_load) begin
      out_value_r <= rd0;
      out_last_r  <= e_final;
      out_inv_r   <= inv_r;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;
  assign out_inv   = out_inv_r;
  assign out_ovf   = out_ovf_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ELEMENTS))
    else $error("element count beyond capacity");

  a_seg_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (i_r <= mid_r && mid_r <= hi_r && hi_r <= cnt_r && k_r < hi_r))
    else $error("merge segment bounds out of order");

  a_inv_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(inv_r) <= 32'(INV_BOUND))
    else $error("inversion count above pair count");

  a_final_out: assert property (@(posedge clk) disable iff (!rst_n)
    stat.emit_final |=> (out_valid && out_last))
    else $error("final result not marked last");
`endif

endmodule

`default_nettype wire

// File: design/merge_sort_inversion_count_unit.sv
`default_nettype none

// Merge sort with inversion count.
// in_ch carries one signed 32-bit value per item; the item with is_last set
// closes the set. Up to 64 values are stored; items beyond that are dropped
// and flag overflow, though a dropped is_last item still closes the set.
// in_ch.ready is high only while loading, one item per cycle.
// After the closing item the block sorts: a setup step, then
// ceil(log2(n)) merge passes of n moves each, one element moved per cycle
// through the two read ports of the source bank. The first read is then
// primed, and out_ch delivers the n sorted values at up to one per cycle,
// each with the set's inversion count and overflow flag, the last marked.
// Inputs are taken again as soon as the final result enters the output
// register. A stall on out_ch holds the output register and pauses emission.
// Synchronous reset empties the store, clears the count, overflow and
// inversion state and drops any result not yet taken.
module merge_sort_inversion_count_unit import msic_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  msic_in_if.sink     in_ch,
  msic_out_if.source  out_ch
);

  msic_cmd_t  cmd;
  msic_stat_t stat;

  assign in_ch.ready = cmd.load;

  msic_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  msic_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_valid   (in_ch.valid),
    .in_value   (in_ch.value),
    .in_is_last (in_ch.is_last),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_value  (out_ch.sorted_value),
    .out_last   (out_ch.last_out),
    .out_inv    (out_ch.inversion_total),
    .out_ovf    (out_ch.overflow)
  );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none

module tb_top;
  import msic_pkg::*;

  localparam int MAX_GAP        = 16;
  localparam int HOLD_CYCLES    = 300;
  localparam int STALL_LIMIT    = 5000;
  localparam int SETTLE_CYCLES  = 50;
  localparam int RANDOM_ITEMS   = 200;
  localparam int REPORT_LIMIT   = 10;

  localparam logic signed [DATA_W-1:0] VALUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VALUE_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  // How random set contents are drawn
  typedef enum int {
    STYLE_FULL,
    STYLE_NARROW,
    STYLE_CORNER
  } value_style_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic [INV_W-1:0]         inversions;
    logic                     overflow;
  } sorted_result_t;

  logic clk;
  logic rst_n;

  msic_in_if  in_ch();
  msic_out_if out_ch();

  merge_sort_inversion_count_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow of the set being loaded and the results it will produce
  logic signed [DATA_W-1:0] set_under_load[$];
  logic                     set_overflow;
  sorted_result_t           sorted_results_due[$];

  int tx_max_gap;
  int rx_max_gap;
  bit hold_request;

  int items_sent;
  int items_dropped;
  int sets_closed;
  int overflow_sets;
  int results_checked;
  int mismatch_count;
  int max_inversions;
  int holds_done;
  int stall_cycles;

  // Clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Offer one item, wait for acceptance, then fold it into the shadow set
  task automatic send_element(input logic signed [DATA_W-1:0] value, input logic last);
    int gap;
    int n;
    int i;
    int j;
    int unsigned inversions;
    logic signed [DATA_W-1:0] ordered[$];
    logic signed [DATA_W-1:0] key;
    sorted_result_t r;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.value   <= value;
    in_ch.is_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;

    // Store is full: the item is dropped but can still close the set
    if (set_under_load.size() < MAX_ELEMENTS) begin
      set_under_load.push_back(value);
    end else begin
      set_overflow = 1'b1;
      items_dropped++;
    end

    if (last) begin
      n = set_under_load.size();
      // Pair count equals the merge count; saturate at the register width
      inversions = 0;
      for (i = 0; i < n; i++) begin
        for (j = i + 1; j < n; j++) begin
          if (set_under_load[i] > set_under_load[j]) inversions++;
        end
      end
      if (inversions > INV_MAX) inversions = INV_MAX;
      // Ascending order, ties keep arrival order
      ordered = set_under_load;
      for (i = 1; i < n; i++) begin
        key = ordered[i];
        j = i - 1;
        while (j >= 0 && ordered[j] > key) begin
          ordered[j+1] = ordered[j];
          j--;
        end
        ordered[j+1] = key;
      end
      for (i = 0; i < n; i++) begin
        r.value      = ordered[i];
        r.last       = (i == n - 1);
        r.inversions = inversions[INV_W-1:0];
        r.overflow   = set_overflow;
        sorted_results_due.push_back(r);
      end
      if (inversions > max_inversions) max_inversions = inversions;
      if (set_overflow) overflow_sets++;
      sets_closed++;
      set_under_load.delete();
      set_overflow = 1'b0;
    end
    @(negedge clk);
  endtask

  // Hold the sender idle until every due result has been taken
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    while (sorted_results_due.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] draw_value(input value_style_t style);
    logic signed [DATA_W-1:0] v;
    case (style)
      STYLE_NARROW: begin
        v = $signed($urandom_range(0, 8)) - 4;
      end
      STYLE_CORNER: begin
        case ($urandom_range(0, 5))
          0:       v = VALUE_MIN;
          1:       v = VALUE_MAX;
          2:       v = '0;
          3:       v = -1;
          4:       v = 1;
          default: v = $urandom;
        endcase
      end
      default: begin
        v = $urandom;
      end
    endcase
    return v;
  endfunction

  task automatic send_random_set(input int size, input value_style_t style);
    int k;
    for (k = 0; k < size; k++) begin
      send_element(draw_value(style), k == size - 1);
    end
  endtask

  // Two single element sets
  task automatic test_single_element();
    send_element(VALUE_MAX, 1'b1);
    send_element(VALUE_MIN, 1'b1);
  endtask

  // Sign boundaries and zero
  task automatic test_extreme_values();
    send_element(VALUE_MAX, 1'b0);
    send_element(VALUE_MIN, 1'b0);
    send_element(32'sd0, 1'b0);
    send_element(-32'sd1, 1'b0);
    send_element(32'sd1, 1'b1);
  endtask

  // Equal values must not count as inversions
  task automatic test_equal_values();
    send_element(32'sd3, 1'b0);
    send_element(32'sd3, 1'b0);
    send_element(-32'sd3, 1'b0);
    send_element(32'sd3, 1'b0);
    send_element(-32'sd3, 1'b1);
  endtask

  // Strictly descending: every pair inverted
  task automatic test_reverse_order();
    int k;
    for (k = 0; k < 8; k++) begin
      send_element(32'sd400 - 32'sd100 * k, k == 7);
    end
  endtask

  // Full store, descending: largest possible inversion count
  task automatic test_full_store();
    int k;
    tx_max_gap = 2;
    rx_max_gap = 2;
    for (k = 0; k < MAX_ELEMENTS; k++) begin
      send_element(VALUE_MAX - k * 32'sd1000, k == MAX_ELEMENTS - 1);
    end
  endtask

  // Extras dropped, a dropped closing item still ends the set, flag clears after
  task automatic test_overflow_drop();
    int k;
    tx_max_gap = MAX_GAP;
    rx_max_gap = MAX_GAP;
    for (k = 0; k < MAX_ELEMENTS + 2; k++) begin
      send_element(draw_value(STYLE_FULL), k == MAX_ELEMENTS + 1);
    end
    tx_max_gap = 0;
    rx_max_gap = 0;
    send_random_set(MAX_ELEMENTS + 1, STYLE_NARROW);
    send_random_set(2, STYLE_CORNER);
  endtask

  // Receiver stalls for a long stretch while the sender keeps offering items
  task automatic test_backpressure_fill();
    tx_max_gap = 0;
    rx_max_gap = 3;
    hold_request = 1'b1;
    send_random_set(40, STYLE_FULL);
    send_random_set(10, STYLE_NARROW);
    wait_for_drain();
    send_random_set(5, STYLE_CORNER);
  endtask

  // Random sets, mostly small, with random idle settings per set
  task automatic test_random_sets();
    int goal;
    int size;
    int pick;
    value_style_t style;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) size = $urandom_range(1, 10);
      else if (pick < 95) size = $urandom_range(11, MAX_ELEMENTS);
      else size = $urandom_range(MAX_ELEMENTS + 1, MAX_ELEMENTS + 6);
      pick = $urandom_range(0, 2);
      style = (pick == 0) ? STYLE_FULL : (pick == 1) ? STYLE_NARROW : STYLE_CORNER;
      pick = $urandom_range(0, 3);
      tx_max_gap = (pick == 0) ? 0 : (pick == 1) ? 3 : MAX_GAP;
      pick = $urandom_range(0, 3);
      rx_max_gap = (pick == 0) ? 0 : (pick == 1) ? 3 : MAX_GAP;
      send_random_set(size, style);
      if ($urandom_range(0, 9) == 0) wait_for_drain();
    end
  endtask

  // Main sequence
  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.value   = '0;
    in_ch.is_last = 1'b0;
    set_overflow  = 1'b0;
    tx_max_gap    = MAX_GAP;
    rx_max_gap    = MAX_GAP;
    hold_request  = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_single_element();
    test_extreme_values();
    test_equal_values();
    test_reverse_order();
    test_full_store();
    test_overflow_drop();
    test_backpressure_fill();
    test_random_sets();

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Covered %0d sets from %0d items (%0d dropped, %0d sets overflowed, %0d long holds).",
             sets_closed, items_sent, items_dropped, overflow_sets, holds_done);
    $display("Checked %0d sorted items, largest inversion count %0d, %0d mismatches.",
             results_checked, max_inversions, mismatch_count);
    if (mismatch_count == 0 && sorted_results_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver: random stall per item, plus one long hold on request
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        gap = HOLD_CYCLES;
        hold_request = 1'b0;
        holds_done++;
      end else begin
        gap = $urandom_range(0, rx_max_gap);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Compare each accepted result with the oldest one due
  sorted_result_t got_result;
  sorted_result_t due_result;
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_result.value      = out_ch.sorted_value;
      got_result.last       = out_ch.last_out;
      got_result.inversions = out_ch.inversion_total;
      got_result.overflow   = out_ch.overflow;
      if (sorted_results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("Unexpected item: value=%0d last=%0b inv=%0d ovf=%0b",
                   got_result.value, got_result.last, got_result.inversions,
                   got_result.overflow);
        end
      end else begin
        due_result = sorted_results_due.pop_front();
        results_checked++;
        if (got_result.value !== due_result.value || got_result.last !== due_result.last ||
            got_result.inversions !== due_result.inversions ||
            got_result.overflow !== due_result.overflow) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("Mismatch on item %0d: expected value=%0d last=%0b inv=%0d ovf=%0b",
                     results_checked, due_result.value, due_result.last,
                     due_result.inversions, due_result.overflow);
            $display("                      actual   value=%0d last=%0b inv=%0d ovf=%0b",
                     got_result.value, got_result.last, got_result.inversions,
                     got_result.overflow);
          end
        end
      end
    end
  end

  // Watchdog: too long without any handshake on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles, %0d items still due",
                 stall_cycles, sorted_results_due.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
